@@ design/fir_fc_pkg.sv @@
// -----------------------------------------------------------------------------
// FIR full-convolution package
// Shared sizes, payload structs, action codes and controller states for the
// FIR full-convolution unit.
// -----------------------------------------------------------------------------
package fir_fc_pkg;

  // Sizes of the filter.
  localparam int MAX_TAPS    = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int TAP_AW      = $clog2(MAX_TAPS);
  localparam int TAP_CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int PROD_W      = 2 * SAMPLE_BITS;

  // Fixed field widths of the channels and the register.
  localparam int TAP_IDX_W = 4;
  localparam int FILT_W    = 36;
  localparam int CFG_W     = 5;

  // Reset value of the tap count register.
  localparam logic [CFG_W-1:0] TAP_COUNT_RESET = CFG_W'(MAX_TAPS);

  // Action codes of an input item.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // One input item.
  typedef struct packed {
    logic                          action;
    logic [TAP_IDX_W-1:0]          tap_index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          end_of_row;
  } fir_in_t;

  // One result item.
  typedef struct packed {
    logic signed [FILT_W-1:0] filtered_value;
    logic                     last_of_row;
  } fir_out_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } fir_state_e;

endpackage

@@ design/fir_full_convolution_unit.sv @@
// -----------------------------------------------------------------------------
// FIR full-convolution unit
// Direct-form FIR filter with the sample history held in a ring memory and
// the coefficients in a second memory, walked by one shared multiply-add.
// -----------------------------------------------------------------------------
// Usage:
// Input items arrive on in_valid_i/in_data_i and are taken when in_stall_o is
// low. An item with action ACT_LOAD writes one coefficient and gives no
// result. An item with action ACT_SAMPLE gives one result; when it also
// carries end_of_row it is followed by tap_count-1 flush results, the last
// of which is marked last_of_row, and the sample history is then cleared.
// Each result is made in steps: the sample is written into the ring memory,
// both memories are read once per tap, the registered read and the
// multiplier form the pipeline, the last product is added, and the
// sum is handed to the output register. The single multiply-add walks the
// taps; the unit works on one input item at a time and takes no new item
// until it is done with a sample and its flush results, while coefficient
// loads can follow every cycle while the unit is idle.
// Results leave through an output register on out_valid_o/out_res_o; a high
// out_stall_i holds that register, and the unit carries on with the next
// result or item until it needs the register again.
// The user writes the tap count register through cfg_valid_i/cfg_data_i
// only while the unit is idle; the unit does not enforce this. Reset clears
// all coefficients and history (per-entry valid bits) and maxes the tap count.
// -----------------------------------------------------------------------------
module fir_full_convolution_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  fir_fc_pkg::fir_in_t       in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output fir_fc_pkg::fir_out_t      out_res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [fir_fc_pkg::CFG_W-1:0] cfg_data_i
);

  import fir_fc_pkg::*;

  // Memories and their valid bits.
  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]           coef_vld_q;
  logic [MAX_TAPS-1:0]           ring_vld_q;

  // Control state.
  fir_state_e                    state_q, state_d;
  logic [CFG_W-1:0]              tap_count_q;
  logic [TAP_CNT_W-1:0]          taps_eff;
  logic [TAP_CNT_W-1:0]          tap_cnt_q;
  logic [TAP_CNT_W-1:0]          flush_left_q;
  logic                          row_end_q;
  logic [TAP_AW-1:0]             wp_q;
  logic signed [SAMPLE_BITS-1:0] samp_q;

  // Datapath pipeline.
  logic                          rd_vld_q;
  logic signed [SAMPLE_BITS-1:0] coef_rd_q;
  logic signed [SAMPLE_BITS-1:0] smp_rd_q;
  logic                          prod_vld_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [FILT_W-1:0]      acc_q;

  // Output register.
  logic                          out_vld_q;
  fir_out_t                      out_q;

  // Control strobes.
  logic              idle;
  logic              coef_we;
  logic              smp_acc;
  logic              ring_we;
  logic              rd_issue;
  logic              out_load;
  logic              last_res;
  logic              ring_clr;
  logic              flush_next;
  logic [TAP_AW-1:0] coef_ra;
  logic [TAP_AW-1:0] ring_ra;

  // Tap count in use: zero behaves as one, larger values saturate.
  always_comb begin
    if (tap_count_q == '0) begin
      taps_eff = TAP_CNT_W'(1);
    end else if (32'(tap_count_q) > MAX_TAPS) begin
      taps_eff = TAP_CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = TAP_CNT_W'(tap_count_q);
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_data_i.action == ACT_SAMPLE)) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: state_d = ST_READ;
      ST_READ: begin
        if (tap_cnt_q == taps_eff - TAP_CNT_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !prod_vld_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_vld_q || !out_stall_i) begin
          state_d = (row_end_q && (flush_left_q != '0)) ? ST_WRITE : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output and strobe logic.
  always_comb begin
    idle       = (state_q == ST_IDLE);
    coef_we    = idle && in_valid_i && (in_data_i.action == ACT_LOAD);
    smp_acc    = idle && in_valid_i && (in_data_i.action == ACT_SAMPLE);
    ring_we    = (state_q == ST_WRITE);
    rd_issue   = (state_q == ST_READ);
    out_load   = (state_q == ST_EMIT) && (!out_vld_q || !out_stall_i);
    last_res   = row_end_q && (flush_left_q == '0);
    ring_clr   = out_load && last_res;
    flush_next = out_load && row_end_q && (flush_left_q != '0);
    coef_ra    = tap_cnt_q[TAP_AW-1:0];
    ring_ra    = wp_q - TAP_AW'(1) - tap_cnt_q[TAP_AW-1:0];
  end

  assign in_stall_o  = !idle;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

  // Controller registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tap_count_q  <= TAP_COUNT_RESET;
      tap_cnt_q    <= '0;
      flush_left_q <= '0;
      row_end_q    <= 1'b0;
      wp_q         <= '0;
      rd_vld_q     <= 1'b0;
      prod_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= rd_issue;
      prod_vld_q <= rd_vld_q;
      if (cfg_valid_i && cfg_ready_o) begin
        tap_count_q <= cfg_data_i;
      end
      if (smp_acc) begin
        row_end_q    <= in_data_i.end_of_row;
        flush_left_q <= taps_eff - TAP_CNT_W'(1);
      end else if (flush_next) begin
        flush_left_q <= flush_left_q - TAP_CNT_W'(1);
      end
      if (ring_we) begin
        wp_q      <= wp_q + TAP_AW'(1);
        tap_cnt_q <= '0;
      end else if (rd_issue) begin
        tap_cnt_q <= tap_cnt_q + TAP_CNT_W'(1);
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Valid bits of both memories: an invalid entry reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      ring_vld_q <= '0;
    end else begin
      if (coef_we) begin
        coef_vld_q[TAP_AW'(in_data_i.tap_index)] <= 1'b1;
      end
      if (ring_clr) begin
        ring_vld_q <= '0;
      end else if (ring_we) begin
        ring_vld_q[wp_q] <= 1'b1;
      end
    end
  end

  // Sample to shift in: the accepted sample, then zeros while flushing.
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      samp_q <= in_data_i.value;
    end else if (flush_next) begin
      samp_q <= '0;
    end
  end

  // Coefficient memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[TAP_AW'(in_data_i.tap_index)] <= in_data_i.value;
    end
    if (rd_issue) begin
      coef_rd_q <= coef_vld_q[coef_ra] ? coef_mem[coef_ra] : '0;
    end
  end

  // Sample ring memory: the newest sample sits just below the write pointer.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wp_q] <= samp_q;
    end
    if (rd_issue) begin
      smp_rd_q <= ring_vld_q[ring_ra] ? ring_mem[ring_ra] : '0;
    end
  end

  // Multiply, then accumulate into the exact sum.
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= coef_rd_q * smp_rd_q;
    end
    if (ring_we) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + FILT_W'(prod_q);
    end
  end

  // Output register load.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.filtered_value <= acc_q;
      out_q.last_of_row    <= last_res;
    end
  end

  // The read walk never passes the tap count in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (tap_cnt_q < taps_eff))
    else $error("tap walk ran past the tap count");

  // A sum is only handed over once the multiply-add pipeline is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!rd_vld_q && !prod_vld_q))
    else $error("result handed over with products still in flight");

  // After the final result of a row the history is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_clr |=> (ring_vld_q == '0))
    else $error("sample history not cleared at the end of a row");

  // A loaded result stays in the output register until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |-> !out_load)
    else $error("output register overwritten while stalled");

endmodule
